// ----- rtl/edfmlt_pkg.sv -----
// shared types, constants and saturating arithmetic for the edf lateness tracker
// no dependencies; imported by every module of the block
package edfmlt_pkg;

    localparam int SLOTS_DEF = 1024;

    localparam int DL_W   = 10;
    localparam int DUR_W  = 10;
    localparam int LAT_W  = 32;
    localparam int VAL_W  = 40;
    localparam int IN_W   = 8 * ((DL_W + DUR_W + 7) / 8);

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        val_t best;
        val_t shift;
    } node_t;

    // one step of the root-to-leaf walk
    typedef struct packed {
        logic valid;
        logic leaf;
        logic term;
        logic add_sib;
    } walk_step_t;

    localparam val_t EMPTY_MARK = {1'b1, {(VAL_W-1){1'b0}}};
    localparam val_t VAL_CAP    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t LAT_TOP    = {{(VAL_W-LAT_W){1'b0}}, {LAT_W{1'b1}}};
    localparam val_t VAL_ZERO   = '0;
    localparam logic [LAT_W-1:0] LAT_CAP = '1;

    // operands never go below the empty mark, so only the upper bound can trip
    function automatic val_t sat_add(val_t a, val_t b);
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        if (s > $signed({1'b0, VAL_CAP}))
            return VAL_CAP;
        return s[VAL_W-1:0];
    endfunction

    function automatic val_t val_max(val_t a, val_t b);
        return (a > b) ? a : b;
    endfunction

    // subtree maximum seen from the parent: empty stays empty
    function automatic val_t node_eff(val_t best, val_t shift);
        if (best == EMPTY_MARK)
            return EMPTY_MARK;
        return sat_add(best, shift);
    endfunction

    function automatic logic [LAT_W-1:0] clamp_lat(val_t v);
        if (v[VAL_W-1] || v == VAL_ZERO)
            return '0;
        if (v > LAT_TOP)
            return LAT_CAP;
        return v[LAT_W-1:0];
    endfunction

endpackage

// ----- rtl/edf_max_lateness_tracker.sv -----
// edf maximum-lateness tracker: range-add / range-max segment tree over deadline slots
// a task walks from the root down to its deadline leaf, at depth ceil(log2 SLOTS) or one
//   less, and back up through the node memory; one task at a time, a new request is taken
//   only once the last result is loaded; out-of-range deadline: no walk, current answer
// reset: async active low; a clearing pass then writes every node
//   (empty best, zero shift) before the first request is taken
module edf_max_lateness_tracker
    import edfmlt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // task requests
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // deadline [9:0], duration [19:10], zero fill
    // results
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [LAT_W-1:0] m_tdata    // lateness [31:0]
);

    localparam int NODES = 2 * SLOTS;
    localparam int AW    = $clog2(NODES);
    localparam int SW    = $clog2(SLOTS + 1);
    localparam int DMAX  = $clog2(SLOTS);
    localparam int SD    = DMAX + 1;
    localparam int DW    = $clog2(SD);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DESC,
        ST_ASC,
        ST_OUT
    } state_t;

    state_t state_reg;

    // input request fields
    logic [DL_W-1:0]  s_deadline;
    logic [DUR_W-1:0] s_duration;
    logic             in_acc, in_range, walk_start;

    assign s_deadline = s_tdata[DL_W-1:0];
    assign s_duration = s_tdata[DL_W+DUR_W-1:DL_W];
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign in_range   = 32'(s_deadline) < 32'(SLOTS);
    assign walk_start = in_acc && in_range;

    // per-task operands
    val_t dur_reg, neg_from_reg;

    always_ff @(posedge clk)
    begin
        if (walk_start)
        begin
            dur_reg      <= val_t'(s_duration);
            neg_from_reg <= VAL_ZERO - val_t'(s_deadline);
        end
    end

    // descent address walker
    walk_step_t    walk_step;
    logic [AW-1:0] walk_path, walk_sib;
    logic [DW-1:0] walk_depth;

    edfmlt_walker #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .SW    (SW),
        .DW    (DW)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (walk_start),
        .from      (SW'(s_deadline)),
        .step      (walk_step),
        .path_addr (walk_path),
        .sib_addr  (walk_sib),
        .depth     (walk_depth)
    );

    // node memory
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    node_t         mem_wr_data;
    node_t         rd_path, rd_sib;

    edfmlt_tree_mem #(
        .DEPTH (NODES),
        .AW    (AW)
    ) u_tree_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_en     (walk_step.valid),
        .rd_addr_a (walk_path),
        .rd_addr_b (walk_sib),
        .rd_data_a (rd_path),
        .rd_data_b (rd_sib)
    );

    // stage 1: step info lined up with the read data
    walk_step_t    s1_step_reg;
    logic [AW-1:0] s1_path_reg, s1_sib_reg;
    logic [DW-1:0] s1_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_step_reg <= '0;
        end
        else
        begin
            s1_step_reg <= walk_step;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_path_reg  <= walk_path;
        s1_sib_reg   <= walk_sib;
        s1_depth_reg <= walk_depth;
    end

    // stage 1 modify: suffix add on the terminal node and right siblings, mark on the leaf
    val_t p1_path_shift, p1_path_best, p1_sib_shift;
    logic p1_sib_wr, p1_leaf_wr;

    always_comb
    begin
        p1_path_shift = s1_step_reg.term ? sat_add(rd_path.shift, dur_reg) : rd_path.shift;
        p1_path_best  = s1_step_reg.leaf ? val_max(rd_path.best, neg_from_reg) : rd_path.best;
        p1_sib_shift  = s1_step_reg.add_sib ? sat_add(rd_sib.shift, dur_reg) : rd_sib.shift;
        p1_sib_wr     = s1_step_reg.valid && s1_step_reg.add_sib;
        p1_leaf_wr    = s1_step_reg.valid && s1_step_reg.leaf;
    end

    // stage 2: effective values for the ascent
    logic          s2_valid_reg, s2_leaf_reg;
    logic [AW-1:0] s2_path_reg;
    logic [DW-1:0] s2_depth_reg;
    node_t         s2_path_node_reg, s2_sib_node_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_leaf_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_step_reg.valid;
            s2_leaf_reg  <= s1_step_reg.valid && s1_step_reg.leaf;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_path_reg            <= s1_path_reg;
        s2_depth_reg           <= s1_depth_reg;
        s2_path_node_reg.best  <= p1_path_best;
        s2_path_node_reg.shift <= p1_path_shift;
        s2_sib_node_reg.best   <= rd_sib.best;
        s2_sib_node_reg.shift  <= p1_sib_shift;
    end

    // path stack: per depth the path node address and shift, and the effective value of
    // the sibling below it (kept at the parent's depth)
    logic [AW-1:0] stack_addr  [SD];
    val_t          stack_shift [SD];
    val_t          stack_sib   [SD];

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            stack_addr[s2_depth_reg]  <= s2_path_reg;
            stack_shift[s2_depth_reg] <= s2_path_node_reg.shift;
            if (s2_depth_reg != '0)
            begin
                stack_sib[s2_depth_reg - DW'(1)] <=
                    node_eff(s2_sib_node_reg.best, s2_sib_node_reg.shift);
            end
        end
    end

    // ascent: recompute each path node's maximum from its two children, leaf to root
    logic [DW-1:0] asc_k_reg;
    logic [AW-1:0] clr_reg;
    val_t          cur_eff_reg, cur_eff_next;
    val_t          asc_best;
    val_t          asc_shift;

    always_comb
    begin
        asc_shift = stack_shift[asc_k_reg];
        asc_best  = val_max(cur_eff_reg, stack_sib[asc_k_reg]);
    end

    // cur_eff holds the root's effective value between tasks, so it is reset
    always_comb
    begin
        cur_eff_next = cur_eff_reg;
        if (s2_leaf_reg)
        begin
            cur_eff_next = node_eff(s2_path_node_reg.best, s2_path_node_reg.shift);
        end
        else if (state_reg == ST_ASC)
        begin
            cur_eff_next = node_eff(asc_best, asc_shift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_eff_reg <= EMPTY_MARK;
        end
        else
        begin
            cur_eff_reg <= cur_eff_next;
        end
    end

    // write port: clearing pass, descent updates, ascent write-back
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = s1_path_reg;
        mem_wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = clr_reg;
            mem_wr_data.best  = EMPTY_MARK;
            mem_wr_data.shift = VAL_ZERO;
        end
        else if (p1_sib_wr)
        begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = s1_sib_reg;
            mem_wr_data.best  = rd_sib.best;
            mem_wr_data.shift = p1_sib_shift;
        end
        else if (p1_leaf_wr)
        begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = s1_path_reg;
            mem_wr_data.best  = p1_path_best;
            mem_wr_data.shift = p1_path_shift;
        end
        else if (state_reg == ST_ASC)
        begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = stack_addr[asc_k_reg];
            mem_wr_data.best  = asc_best;
            mem_wr_data.shift = asc_shift;
        end
    end

    // sequencer and result register
    logic             m_tvalid_reg;
    logic [LAT_W-1:0] m_tdata_reg;
    logic             out_load;
    logic [LAT_W-1:0] lat_next;

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign lat_next = clamp_lat(cur_eff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            asc_k_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(NODES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        // a deadline past the last slot only repeats the current answer
                        state_reg <= in_range ? ST_DESC : ST_OUT;
                    end
                end
                ST_DESC:
                begin
                    if (s2_leaf_reg)
                    begin
                        asc_k_reg <= s2_depth_reg - DW'(1);
                        state_reg <= ST_ASC;
                    end
                end
                ST_ASC:
                begin
                    if (asc_k_reg == '0)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        asc_k_reg <= asc_k_reg - DW'(1);
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= lat_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a sibling add and a leaf mark never land in the same cycle
    a_one_descent_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(p1_sib_wr && p1_leaf_wr))
        else $error("descent sibling and leaf writes collide");

    // the walk never goes deeper than the tree
    a_walk_depth: assert property (@(posedge clk) disable iff (!rst_n)
        walk_step.valid |-> (walk_depth <= DW'(DMAX)))
        else $error("walker depth beyond tree height");

    // adding tasks can only raise the maximum lateness
    a_lateness_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (lat_next >= m_tdata_reg))
        else $error("reported lateness decreased");

    // the ascent starts only after the descent pipeline has drained
    a_asc_after_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ASC) |-> (!s1_step_reg.valid && !walk_step.valid))
        else $error("ascent overlaps descent");

endmodule

// ----- rtl/edfmlt_tree_mem.sv -----
// node store of the segment tree: one write port, two registered read ports
// depends on edfmlt_pkg for the node word type
module edfmlt_tree_mem
    import edfmlt_pkg::*;
#(
    parameter int DEPTH = 2 * SLOTS_DEF,
    parameter int AW    = $clog2(2 * SLOTS_DEF)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  node_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output node_t         rd_data_a,
    output node_t         rd_data_b
);

    node_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- rtl/edfmlt_walker.sv -----
// address walker: steps from the root to the leaf of the deadline slot, one level a cycle
// depends on edfmlt_pkg for the step struct
module edfmlt_walker
    import edfmlt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int AW    = $clog2(2 * SLOTS_DEF),
    parameter int SW    = $clog2(SLOTS_DEF + 1),
    parameter int DW    = $clog2($clog2(SLOTS_DEF) + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [SW-1:0] from,
    output walk_step_t    step,
    output logic [AW-1:0] path_addr,
    output logic [AW-1:0] sib_addr,
    output logic [DW-1:0] depth
);

    localparam int XW = AW + 1;

    walk_step_t    step_reg, step_next;
    logic [AW-1:0] idx_reg, sib_reg;
    logic [SW-1:0] lo_reg, hi_reg, from_reg;
    logic [DW-1:0] depth_reg;

    logic [SW-1:0] span, mid, off, c_lo, c_hi;
    logic [AW-1:0] near_idx, far_idx;
    logic          go_left, past_lo;

    always_comb
    begin
        span     = hi_reg - lo_reg;
        mid      = lo_reg + (span >> 1);
        off      = mid - lo_reg;
        go_left  = from_reg < mid;
        past_lo  = from_reg > lo_reg;
        near_idx = idx_reg + AW'(1);
        far_idx  = AW'(XW'(idx_reg) + (XW'(off) << 1));
        c_lo     = go_left ? lo_reg : mid;
        c_hi     = go_left ? mid : hi_reg;

        step_next.valid   = 1'b1;
        step_next.leaf    = (c_hi - c_lo) == SW'(1);
        // first node on the path whose range starts at the deadline takes the add
        step_next.term    = past_lo && (c_lo == from_reg);
        // right sibling fully inside the suffix gets the add
        step_next.add_sib = go_left && past_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            idx_reg   <= '0;
            sib_reg   <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            from_reg  <= '0;
            depth_reg <= '0;
        end
        else if (start)
        begin
            step_reg.valid   <= 1'b1;
            step_reg.leaf    <= 1'b0;
            step_reg.term    <= (from == '0);
            step_reg.add_sib <= 1'b0;
            idx_reg          <= '0;
            sib_reg          <= '0;
            lo_reg           <= '0;
            hi_reg           <= SW'(SLOTS);
            from_reg         <= from;
            depth_reg        <= '0;
        end
        else if (step_reg.valid && !step_reg.leaf)
        begin
            step_reg  <= step_next;
            idx_reg   <= go_left ? near_idx : far_idx;
            sib_reg   <= go_left ? far_idx : near_idx;
            lo_reg    <= c_lo;
            hi_reg    <= c_hi;
            depth_reg <= depth_reg + DW'(1);
        end
        else
        begin
            step_reg.valid <= 1'b0;
        end
    end

    assign step      = step_reg;
    assign path_addr = idx_reg;
    assign sib_addr  = sib_reg;
    assign depth     = depth_reg;

endmodule

// ----- dv/tb.sv -----
// self-checking bench for edf_max_lateness_tracker: a directed table, then random tasks,
// with random idle cycles and stalls on both stream sides; depends on rtl/edfmlt_pkg.sv
// and rtl/edf_max_lateness_tracker.sv
`timescale 1ns / 100ps

module tb
    import edfmlt_pkg::*;
();

    localparam int SLOT_COUNT  = SLOTS_DEF;
    localparam int RANDOM_REQS = 1935;
    // cycles with no handshake on either side; covers the clearing pass after reset
    localparam int STALL_LIMIT = 4 * SLOT_COUNT + 4000;
    // settling time after the last expected result, to watch for stray results
    localparam int SETTLE_CYCLES = 60;

    // one row of the directed table; pinned rows carry a hand-worked lateness
    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [DUR_W-1:0] duration;
        logic             pinned;
        logic [LAT_W-1:0] lateness;
    } task_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;    // deadline [9:0], duration [19:10], zero fill
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [LAT_W-1:0] m_tdata;         // lateness [31:0]

    // expected lateness values, oldest first
    logic [LAT_W-1:0] lateness_q [$];
    int               fails = 0;
    int               idle_cycles = 0;
    bit               tx_calm = 1'b0;
    bit               rx_calm = 1'b0;

    // flat view of the tree: total duration due at each slot and whether it is active
    val_t             due_sum [SLOT_COUNT];
    bit               slot_live [SLOT_COUNT];

    task_row_t directed_rows [16] = '{
        // first task, zero duration at slot zero: lateness exactly zero
        '{10'd0,    10'd0,    1'b1, 32'd0},
        // last slot with nothing due before it: value is negative, clamps to zero
        '{10'd1023, 10'd0,    1'b1, 32'd0},
        // full duration at slot zero
        '{10'd0,    10'd1023, 1'b1, 32'd1023},
        // repeated deadline: slot zero stays active, sum doubles
        '{10'd0,    10'd1023, 1'b1, 32'd2046},
        // last slot catches up with slot zero
        '{10'd1023, 10'd1023, 1'b1, 32'd2046},
        '{10'd512,  10'd1,    1'b0, 32'd0},
        '{10'd511,  10'd1023, 1'b0, 32'd0},
        '{10'd1,    10'h155,  1'b0, 32'd0},
        '{10'h2AA,  10'h2AA,  1'b0, 32'd0},
        '{10'h155,  10'h155,  1'b0, 32'd0},
        '{10'd1022, 10'd1023, 1'b0, 32'd0},
        '{10'd256,  10'd0,    1'b0, 32'd0},
        '{10'd767,  10'd512,  1'b0, 32'd0},
        '{10'd513,  10'd1,    1'b0, 32'd0},
        '{10'd2,    10'd1023, 1'b0, 32'd0},
        '{10'd1023, 10'd1,    1'b0, 32'd0}
    };

    edf_max_lateness_tracker #(
        .SLOTS (SLOT_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // saturating sum, capped at the largest 40-bit value
    function automatic val_t capped_sum(val_t a, val_t b);
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        if (s > $signed({1'b0, VAL_CAP}))
            return VAL_CAP;
        return s[VAL_W-1:0];
    endfunction

    // apply one task and return the edf maximum lateness over all tasks so far:
    // an active slot is worth (duration due by it) - slot, the answer is the max
    // over active slots, clamped at zero and at the 32-bit top
    function automatic logic [LAT_W-1:0] lateness_after(logic [DL_W-1:0] dl,
                                                        logic [DUR_W-1:0] dur);
        val_t run_sum;
        val_t slot_val;
        val_t worst;
        if (int'(dl) < SLOT_COUNT)
        begin
            due_sum[dl]   = capped_sum(due_sum[dl], val_t'(dur));
            slot_live[dl] = 1'b1;
        end
        run_sum = '0;
        worst   = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            run_sum = capped_sum(run_sum, due_sum[i]);
            if (slot_live[i])
            begin
                slot_val = run_sum - val_t'(i);
                if (slot_val > worst)
                    worst = slot_val;
            end
        end
        if (worst > LAT_TOP)
            return '1;
        return worst[LAT_W-1:0];
    endfunction

    // drive one task request; valid is only lowered when a gap follows, so it is
    // never dropped and raised again within one time step
    task automatic send_request(logic [DL_W-1:0] dl, logic [DUR_W-1:0] dur,
                                bit pinned, logic [LAT_W-1:0] pinned_lat, bit drain);
        int               gap;
        logic [LAT_W-1:0] predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            // hold off until the block has handed back every pending result
            if (drain)
                while (lateness_q.size() != 0)
                    @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-DL_W-DUR_W){1'b0}}, dur, dl};
        do
            @(posedge clk);
        while (!s_tready);
        // accepted at this edge: work out what the block must answer
        predicted = lateness_after(dl, dur);
        lateness_q.push_back(pinned ? pinned_lat : predicted);
    endtask

    // reset once, then cleared tree on both sides
    initial
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            due_sum[i]   = '0;
            slot_live[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("edf_max_lateness_tracker test failed");
            $finish;
        end
    end

    // result side: random stalls, compare each result with the oldest expectation
    initial
    begin : result_side
        int               stall;
        logic [LAT_W-1:0] want;
        wait (rst_n);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (lateness_q.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none, got %0d",
                         $time, m_tdata);
                fails++;
            end
            else
            begin
                want = lateness_q.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: lateness mismatch, expected %0d, got %0d",
                             $time, want, m_tdata);
                    fails++;
                end
            end
        end
    end

    // request side: directed table, then random tasks
    initial
    begin : request_side
        logic [DL_W-1:0]  dl;
        logic [DUR_W-1:0] dur;
        int               pick;
        wait (rst_n);
        foreach (directed_rows[r])
            send_request(directed_rows[r].deadline, directed_rows[r].duration,
                         directed_rows[r].pinned, directed_rows[r].lateness, 1'b0);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            // switch between idling and back-to-back stretches now and then
            if (n % 64 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 7);
            if (pick == 0)
                dl = $urandom_range(0, 1) ? '1 : '0;
            else if (pick == 1)
                dl = DL_W'($urandom_range(0, 15));
            else if (pick == 2)
                dl = DL_W'(SLOT_COUNT - 1 - int'($urandom_range(0, 15)));
            else
                dl = DL_W'($urandom_range(0, SLOT_COUNT - 1));
            pick = $urandom_range(0, 7);
            if (pick == 0)
                dur = '0;
            else if (pick == 1)
                dur = '1;
            else if (pick < 4)
                dur = DUR_W'($urandom_range(0, 15));
            else
                dur = DUR_W'($urandom_range(0, 1023));
            send_request(dl, dur, 1'b0, '0, (n % 500) == 250);
        end
        s_tvalid <= 1'b0;

        // let every result drain, then watch for stray results
        while (lateness_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fails == 0 && lateness_q.size() == 0)
            $display("edf_max_lateness_tracker test passed");
        else
            $display("edf_max_lateness_tracker test failed");
        $finish;
    end

endmodule
